// ===== rtl/remove_lock_ownership_table_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the lock ownership table
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef REMOVE_LOCK_OWNERSHIP_TABLE_TOP_MACROS_SVH
`define REMOVE_LOCK_OWNERSHIP_TABLE_TOP_MACROS_SVH

// consequent checked in the same cycle
`define LOT_AST_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent checked in the next cycle
`define LOT_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lot_pkg.sv =====
// ----------------------------------------------------------------------------
// Lock ownership table package
// Command and status codes, request and response payloads, control structs.
// ----------------------------------------------------------------------------
package lot_pkg;

	localparam logic [2:0] CMD_INIT         = 3'd0;
	localparam logic [2:0] CMD_ACQUIRE      = 3'd1;
	localparam logic [2:0] CMD_RELEASE      = 3'd2;
	localparam logic [2:0] CMD_RELEASE_WAIT = 3'd3;
	localparam logic [2:0] CMD_QUERY        = 3'd4;
	localparam logic [2:0] CMD_CHECK        = 3'd5;
	localparam logic [2:0] CMD_FORGET       = 3'd6;

	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_ZERO      = 4'd1;
	localparam logic [3:0] ST_ALIGN     = 4'd2;
	localparam logic [3:0] ST_SIZE      = 4'd3;
	localparam logic [3:0] ST_RANGE     = 4'd4;
	localparam logic [3:0] ST_DUP       = 4'd5;
	localparam logic [3:0] ST_OVERLAP   = 4'd6;
	localparam logic [3:0] ST_FULL      = 4'd7;
	localparam logic [3:0] ST_UNKNOWN   = 4'd8;
	localparam logic [3:0] ST_MISMATCH  = 4'd9;
	localparam logic [3:0] ST_REFLIMIT  = 4'd10;
	localparam logic [3:0] ST_NOTAG     = 4'd11;
	localparam logic [3:0] ST_DRAINING  = 4'd12;
	localparam logic [3:0] ST_PARTIAL   = 4'd13;
	localparam logic [3:0] ST_HASREFS   = 4'd14;

	localparam logic [0:0] CFG_RETAIL = 1'b0;
	localparam logic [0:0] CFG_DEBUG  = 1'b1;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [63:0] base_address;
		logic [63:0] length;
		logic [63:0] tag_value;
		logic [63:0] owner_device;
	} req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic        acquired;
		logic        drained_flag;
		logic [63:0] reg_owner;
		logic [31:0] reg_size;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic sscan;
		logic rscan;
		logic fscan;
		logic commit;
	} dp_ctl_t;

	typedef struct packed {
		logic mod_done;
		logic out_busy;
	} dp_sts_t;

endpackage

// ===== rtl/lot_if.sv =====
// ----------------------------------------------------------------------------
// Lock ownership table channels
// Valid/ready request and response channels.
// ----------------------------------------------------------------------------
interface lot_req_if import lot_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lot_rsp_if import lot_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lot_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/lot_ctrl.sv =====
// ----------------------------------------------------------------------------
// Lock ownership table controller
// Sequences slot scan, tag store scan, range scan and the final update.
// ----------------------------------------------------------------------------
module lot_ctrl import lot_pkg::*; #(
	parameter int LOCK_SLOTS = 16,
	parameter int REF_LIMIT  = 64,
	parameter int IW         = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dp_sts_t       sts,
	output dp_ctl_t       ctl,
	output logic [IW-1:0] idx
);
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SSCAN = 5'b00010,
		S_RSCAN = 5'b00100,
		S_FSCAN = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t state_q;
	logic [IW-1:0] idx_q;
	logic fin_go;

	assign fin_go    = (state_q == S_FIN) && sts.mod_done && !sts.out_busy;
	assign req_ready = (state_q == S_IDLE);
	assign idx       = idx_q;

	always_comb begin
		ctl.start  = (state_q == S_IDLE) && req_valid;
		ctl.sscan  = (state_q == S_SSCAN);
		ctl.rscan  = (state_q == S_RSCAN);
		ctl.fscan  = (state_q == S_FSCAN);
		ctl.commit = fin_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (req_valid) state_q <= S_SSCAN;
				end
				S_SSCAN: begin
					if (idx_q == IW'(LOCK_SLOTS - 1)) begin
						idx_q   <= '0;
						state_q <= S_RSCAN;
					end else idx_q <= idx_q + 1'b1;
				end
				S_RSCAN: begin
					// idx runs on to REF_LIMIT to cover the registered read
					if (idx_q == IW'(REF_LIMIT)) begin
						idx_q   <= '0;
						state_q <= S_FSCAN;
					end else idx_q <= idx_q + 1'b1;
				end
				S_FSCAN: begin
					if (idx_q == IW'(LOCK_SLOTS - 1)) begin
						idx_q   <= '0;
						state_q <= S_FIN;
					end else idx_q <= idx_q + 1'b1;
				end
				S_FIN: begin
					if (fin_go) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/lot_dp.sv =====
// ----------------------------------------------------------------------------
// Lock ownership table datapath
// Slot table, tag store, alignment residue unit, result register.
// ----------------------------------------------------------------------------
module lot_dp import lot_pkg::*; #(
	parameter int LOCK_SLOTS  = 16,
	parameter int REF_LIMIT   = 64,
	parameter int ALIGN_BYTES = 8,
	parameter int IW          = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dp_ctl_t       ctl,
	input  logic [IW-1:0] idx,
	output dp_sts_t       sts,
	input  req_t          req_data,
	output rsp_t          rsp_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  logic          cfg_we,
	input  logic [0:0]    cfg_index,
	input  logic [31:0]   cfg_wdata
);
	localparam int SW   = LOCK_SLOTS > 1 ? $clog2(LOCK_SLOTS) : 1;
	localparam int RW   = REF_LIMIT > 1 ? $clog2(REF_LIMIT) : 1;
	localparam int CW   = $clog2(REF_LIMIT + 1);
	localparam int RA   = ALIGN_BYTES > 1 ? $clog2(ALIGN_BYTES) : 1;
	localparam int RAMW = 64 + SW + CW;
	localparam logic [RA:0] ALIGN_V = ALIGN_BYTES[RA:0];

	// residue tables: byte mod align, and (residue * 256) mod align
	function automatic logic [256*RA-1:0] byte_mod_tbl();
		logic [256*RA-1:0] t;
		t = '0;
		for (int i = 0; i < 256; i++)
			t[i*RA +: RA] = RA'(i % ALIGN_BYTES);
		return t;
	endfunction

	function automatic logic [(1<<RA)*RA-1:0] shift_mod_tbl();
		logic [(1<<RA)*RA-1:0] t;
		t = '0;
		for (int i = 0; i < (1 << RA); i++)
			t[i*RA +: RA] = RA'((i * 256) % ALIGN_BYTES);
		return t;
	endfunction

	localparam logic [256*RA-1:0]     BYTE_MOD  = byte_mod_tbl();
	localparam logic [(1<<RA)*RA-1:0] SHIFT_MOD = shift_mod_tbl();

	// configuration
	logic [31:0] retail_q, debug_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retail_q <= 32'd32;
			debug_q  <= 32'd120;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RETAIL: retail_q <= cfg_wdata;
				CFG_DEBUG:  debug_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// captured request
	logic [2:0]  cmd_q;
	logic [63:0] addr_q, len_q, tag_q, owner_q, end_q;
	logic        ovf_q;
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			cmd_q   <= req_data.cmd;
			addr_q  <= req_data.base_address;
			len_q   <= req_data.length;
			tag_q   <= req_data.tag_value;
			owner_q <= req_data.owner_device;
			end_q   <= req_data.base_address + req_data.length;
			ovf_q   <= req_data.length > ~req_data.base_address;
		end
	end

	// residue of the address by the alignment, one byte a cycle, top byte first
	logic [3:0]    mod_cnt_q;
	logic [63:0]   mod_sh_q;
	logic [RA-1:0] rem_q, rem_hi, rem_lo;
	logic [RA:0]   rem_sum;
	assign rem_hi  = SHIFT_MOD[rem_q * RA +: RA];
	assign rem_lo  = BYTE_MOD[mod_sh_q[63:56] * RA +: RA];
	assign rem_sum = {1'b0, rem_hi} + {1'b0, rem_lo};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_cnt_q <= 4'd8;
			mod_sh_q  <= '0;
			rem_q     <= '0;
		end else if (ctl.start) begin
			mod_cnt_q <= '0;
			mod_sh_q  <= req_data.base_address;
			rem_q     <= '0;
		end else if (!mod_cnt_q[3]) begin
			mod_cnt_q <= mod_cnt_q + 1'b1;
			mod_sh_q  <= {mod_sh_q[55:0], 8'd0};
			rem_q     <= (rem_sum >= ALIGN_V) ? RA'(rem_sum - ALIGN_V) : rem_sum[RA-1:0];
		end
	end

	// slot table
	logic [LOCK_SLOTS-1:0] slot_used_q, slot_drain_q;
	logic [LOCK_SLOTS-1:0] sref_q;
	logic [63:0] slot_addr_q  [LOCK_SLOTS];
	logic [31:0] slot_size_q  [LOCK_SLOTS];
	logic [63:0] slot_owner_q [LOCK_SLOTS];

	logic [SW-1:0] si;
	logic [63:0]   sa;
	logic [64:0]   s_end;
	logic          su, s_hit, s_part;
	assign si     = idx[SW-1:0];
	assign sa     = slot_addr_q[si];
	assign su     = slot_used_q[si];
	assign s_end  = {1'b0, sa} + {33'b0, slot_size_q[si]};
	assign s_hit  = su && (len_q != '0) && ({1'b0, addr_q} < s_end) && (sa < end_q);
	assign s_part = (addr_q > sa) || ({1'b0, end_q} < s_end);

	logic          found_q, fdrain_q, overlap_q, free_v_q;
	logic [SW-1:0] fslot_q, free_q;
	logic [31:0]   fsize_q;
	logic [63:0]   fowner_q;
	logic          best_v_q;
	logic [63:0]   best_addr_q;
	logic [3:0]    best_code_q;
	logic [LOCK_SLOTS-1:0] hit_q;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			found_q   <= 1'b0;
			overlap_q <= 1'b0;
			free_v_q  <= 1'b0;
			best_v_q  <= 1'b0;
			hit_q     <= '0;
		end
		if (ctl.sscan) begin
			if (su && sa == addr_q) begin
				found_q  <= 1'b1;
				fslot_q  <= si;
				fsize_q  <= slot_size_q[si];
				fowner_q <= slot_owner_q[si];
				fdrain_q <= slot_drain_q[si];
			end
			if (!su && !free_v_q) begin
				free_v_q <= 1'b1;
				free_q   <= si;
			end
			if (s_hit) overlap_q <= 1'b1;
		end
		if (ctl.fscan && s_hit) begin
			hit_q[si] <= 1'b1;
			if ((s_part || sref_q[si]) && (!best_v_q || sa < best_addr_q)) begin
				best_v_q    <= 1'b1;
				best_addr_q <= sa;
				best_code_q <= s_part ? ST_PARTIAL : ST_HASREFS;
			end
		end
	end

	// tag store
	logic [REF_LIMIT-1:0]  ref_used_q;
	logic [RAMW-1:0] rdata, wdata;
	logic [63:0]   rd_tag;
	logic [SW-1:0] rd_slot;
	logic [CW-1:0] rd_cnt;
	logic          rv_s1;
	logic [RW-1:0] ridx_s1;
	logic          rmatch_q, other_q, rfree_v_q;
	logic [RW-1:0] rmidx_q, rfree_q;
	logic [CW-1:0] rcnt_q, tot_q;

	logic          ref_we, ref_clr, tot_inc, tot_dec;
	logic [RW-1:0] ref_idx;
	logic [CW-1:0] ref_cnt, cnt_dec;

	assign rd_tag  = rdata[RAMW-1 -: 64];
	assign rd_slot = rdata[SW+CW-1:CW];
	assign rd_cnt  = rdata[CW-1:0];
	assign wdata   = {tag_q, fslot_q, ref_cnt};

	lot_ram #(.WIDTH(RAMW), .DEPTH(REF_LIMIT)) u_refs (
		.clk  (clk),
		.we   (ref_we),
		.waddr(ref_idx),
		.wdata(wdata),
		.raddr(idx[RW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_s1 <= 1'b0;
		else         rv_s1 <= ctl.rscan && (idx < IW'(REF_LIMIT));
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= idx[RW-1:0];
		if (ctl.start) begin
			sref_q    <= '0;
			rmatch_q  <= 1'b0;
			other_q   <= 1'b0;
			rfree_v_q <= 1'b0;
		end else if (rv_s1) begin
			if (ref_used_q[ridx_s1]) begin
				sref_q[rd_slot] <= 1'b1;
				if (found_q && rd_slot == fslot_q) begin
					if (rd_tag == tag_q) begin
						rmatch_q <= 1'b1;
						rmidx_q  <= ridx_s1;
						rcnt_q   <= rd_cnt;
					end else other_q <= 1'b1;
				end
			end else if (!rfree_v_q) begin
				rfree_v_q <= 1'b1;
				rfree_q   <= ridx_s1;
			end
		end
	end

	// final decision
	rsp_t res;
	logic slot_new, drain_set, slot_forget;
	logic [3:0] lk_st;
	assign cnt_dec = rcnt_q - 1'b1;

	always_comb begin
		if (!found_q)                     lk_st = ST_UNKNOWN;
		else if (len_q != {32'b0, fsize_q}) lk_st = ST_MISMATCH;
		else                              lk_st = ST_OK;
	end

	always_comb begin
		res         = '0;
		slot_new    = 1'b0;
		drain_set   = 1'b0;
		slot_forget = 1'b0;
		ref_we      = 1'b0;
		ref_clr     = 1'b0;
		ref_idx     = rmidx_q;
		ref_cnt     = rcnt_q;
		tot_inc     = 1'b0;
		tot_dec     = 1'b0;
		case (cmd_q)
			CMD_INIT: begin
				if (addr_q == '0 || owner_q == '0) res.status = ST_ZERO;
				else if (rem_q != '0) res.status = ST_ALIGN;
				else if (len_q != {32'b0, retail_q} && len_q != {32'b0, debug_q})
					res.status = ST_SIZE;
				else if (ovf_q)     res.status = ST_RANGE;
				else if (found_q)   res.status = ST_DUP;
				else if (overlap_q) res.status = ST_OVERLAP;
				else if (!free_v_q) res.status = ST_FULL;
				else slot_new = 1'b1;
			end
			CMD_ACQUIRE: begin
				if (lk_st != ST_OK) res.status = lk_st;
				else if (fdrain_q) res.status = ST_OK;
				else if (tot_q >= CW'(REF_LIMIT)) res.status = ST_REFLIMIT;
				else if (rmatch_q) begin
					ref_we = 1'b1;
					ref_cnt = rcnt_q + 1'b1;
					tot_inc = 1'b1;
					res.acquired = 1'b1;
				end else if (rfree_v_q) begin
					ref_we = 1'b1;
					ref_idx = rfree_q;
					ref_cnt = CW'(1);
					tot_inc = 1'b1;
					res.acquired = 1'b1;
				end else res.status = ST_REFLIMIT;
			end
			CMD_RELEASE, CMD_RELEASE_WAIT: begin
				if (lk_st != ST_OK) res.status = lk_st;
				else if (cmd_q == CMD_RELEASE_WAIT && fdrain_q) res.status = ST_DRAINING;
				else if (!rmatch_q) res.status = ST_NOTAG;
				else begin
					ref_we  = 1'b1;
					ref_cnt = cnt_dec;
					ref_clr = (cnt_dec == '0);
					tot_dec = (tot_q != '0);
					if (cmd_q == CMD_RELEASE_WAIT) begin
						drain_set = 1'b1;
						res.drained_flag = !other_q && (cnt_dec == '0);
					end
				end
			end
			CMD_QUERY: begin
				if (!found_q) res.status = ST_UNKNOWN;
				else begin
					res.reg_owner    = fowner_q;
					res.reg_size     = fsize_q;
					res.drained_flag = fdrain_q && !sref_q[fslot_q];
				end
			end
			CMD_CHECK: begin
				if (ovf_q) res.status = ST_RANGE;
				else if (overlap_q) res.status = ST_OVERLAP;
			end
			CMD_FORGET: begin
				if (ovf_q) res.status = ST_RANGE;
				else if (len_q == '0) res.status = ST_OK;
				else if (best_v_q) res.status = best_code_q;
				else slot_forget = 1'b1;
			end
			default: ;
		endcase
		if (!ctl.commit) ref_we = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_used_q  <= '0;
			slot_drain_q <= '0;
			ref_used_q   <= '0;
			tot_q        <= '0;
		end else if (ctl.commit) begin
			if (slot_new) begin
				slot_used_q[free_q]  <= 1'b1;
				slot_drain_q[free_q] <= 1'b0;
			end
			if (drain_set) slot_drain_q[fslot_q] <= 1'b1;
			if (slot_forget) begin
				slot_used_q  <= slot_used_q & ~hit_q;
				slot_drain_q <= slot_drain_q & ~hit_q;
			end
			if (ref_we) ref_used_q[ref_idx] <= !ref_clr;
			if (tot_inc)      tot_q <= tot_q + 1'b1;
			else if (tot_dec) tot_q <= tot_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit && slot_new) begin
			slot_addr_q[free_q]  <= addr_q;
			slot_size_q[free_q]  <= len_q[31:0];
			slot_owner_q[free_q] <= owner_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid <= 1'b0;
		else if (ctl.commit) rsp_valid <= 1'b1;
		else if (rsp_ready) rsp_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (ctl.commit) rsp_data <= res;
	end

	assign sts.mod_done = mod_cnt_q[3];
	assign sts.out_busy = rsp_valid && !rsp_ready;
endmodule

// ===== rtl/remove_lock_ownership_table_top.sv =====
// ----------------------------------------------------------------------------
// Lock ownership table top level
// Lock registry with per-tag acquisition counts, controller plus datapath.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  req     | in  | valid / ready   | cmd, base_address, length, tag_value, owner_device
//  rsp     | out | valid / ready   | status, acquired, drained_flag, reg_owner, reg_size
//  cfg     | in  | cfg_we          | cfg_index, cfg_wdata
//
// Each request makes two passes over the slot table and one pass over the tag store.
// The alignment residue runs alongside, one address byte a cycle.
// arst_n clears all valid bits and the reference total; no clearing pass.
// A new request is taken while the previous response waits; a stalled rsp
// holds the final update until the response register frees up.
`include "remove_lock_ownership_table_top_macros.svh"

module remove_lock_ownership_table_top import lot_pkg::*; #(
	parameter int LOCK_SLOTS  = 16,
	parameter int REF_LIMIT   = 64,
	parameter int ALIGN_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	lot_req_if.sink     req,
	lot_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	localparam int IMAX = LOCK_SLOTS > REF_LIMIT ? LOCK_SLOTS : REF_LIMIT;
	localparam int IW   = $clog2(IMAX + 1);

	dp_ctl_t       ctl;
	dp_sts_t       sts;
	logic [IW-1:0] idx;

	lot_ctrl #(.LOCK_SLOTS(LOCK_SLOTS), .REF_LIMIT(REF_LIMIT), .IW(IW)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.ctl      (ctl),
		.idx      (idx)
	);

	lot_dp #(
		.LOCK_SLOTS (LOCK_SLOTS),
		.REF_LIMIT  (REF_LIMIT),
		.ALIGN_BYTES(ALIGN_BYTES),
		.IW         (IW)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.idx      (idx),
		.sts      (sts),
		.req_data (req.data),
		.rsp_data (rsp.data),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	`LOT_AST_NEXT(a_busy_after_req, req.valid && req.ready, !req.ready, "request taken while busy")
	`LOT_AST_NEXT(a_commit_rsp, ctl.commit, rsp.valid, "commit without response")
	`LOT_AST_SAME(a_commit_busy, ctl.commit, !req.ready, "commit while idle")
endmodule
